[rtl/pcnt_pkg.sv]
// Shared types and constants for the point cloud normalize and transform block.
package pcnt_pkg;

  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_NORM   = 3'd1;
  localparam logic [2:0] REQ_CENTER = 3'd2;
  localparam logic [2:0] REQ_ROTATE = 3'd3;
  localparam logic [2:0] REQ_SHIFT  = 3'd4;
  localparam logic [2:0] REQ_READ   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT,
    ST_SCAN,
    ST_DIV,
    ST_APPLY,
    ST_MUL1,
    ST_MUL2,
    ST_WRITE,
    ST_SETUP
  } state_t;

  typedef enum logic [1:0] {
    OP_NORM,
    OP_CENTER,
    OP_ROTATE,
    OP_SHIFT
  } op_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] rnd14(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + 66'sd8192;
    return sat32(t >>> 14);
  endfunction

endpackage

[rtl/pcnt_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module pcnt_div import pcnt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic        [63:0] den,
  output logic               done,
  output logic signed [63:0] quo
);

  logic [63:0] rem;
  logic [63:0] q;
  logic [63:0] d;
  logic [6:0]  cnt;
  logic        neg;
  logic        busy;
  logic [64:0] trial;

  assign trial = {rem, q[63]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= num[63];
        q    <= num[63] ? 64'(-num) : num;
        rem  <= '0;
        d    <= den;
        cnt  <= 7'd64;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], q[63]};
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? -$signed(q) : $signed(q);

endmodule

[rtl/point_cloud_normalize_transform.sv]
// Top level of the point cloud normalize and transform block.
// One request channel (req_valid/req_ready) and one result channel
// (res_valid/res_ready) carry beats. Appends are stored with point_count.
// A read registers its point in ST_READ and presents the beat in ST_OUT;
// an out of range index returns zeros with status set. Normalize, center,
// rotate and shift walk the store held in three synchronous memories: one
// scan pass for the statistics, the iterative divider per value (normalize:
// 3N divisions, center: 3), then a rewrite pass per point through ST_APPLY
// and ST_MUL1, then ST_MUL2 and ST_WRITE for rotate, ST_DIV for normalize
// or ST_WRITE otherwise, set by the single read and write port per
// coordinate memory and the multiply stages of rotate. Appends can follow
// back to back. The request channel is held off while a walk runs.
// A stalled result beat holds and no new request is taken until it leaves.
// Reset clears the point count and the sequencer; memory contents stay.
module point_cloud_normalize_transform import pcnt_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic        [2:0]  req_type,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  input  logic        [9:0]  index,
  input  logic signed [15:0] cos_x,
  input  logic signed [15:0] sin_x,
  input  logic signed [15:0] cos_y,
  input  logic signed [15:0] sin_y,
  input  logic signed [31:0] shift_x,
  input  logic signed [31:0] shift_y,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               status
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > 10) ? CW : 10;

  logic signed [31:0] mem_x [CAPACITY];
  logic signed [31:0] mem_y [CAPACITY];
  logic signed [31:0] mem_z [CAPACITY];

  state_t state, state_next;
  op_t    op;
  logic [CW-1:0] point_count;
  logic [CW-1:0] ptr;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic          fwd;
  logic signed [31:0] rx, ry, rz, wx, wy, wz;
  logic signed [31:0] mnx, mny, mnz, mxx, mxy, mxz;
  logic signed [63:0] sx, sy, sz;
  logic signed [63:0] mx, my, mz;
  logic [32:0] dval;
  logic signed [15:0] cx, snx, cy, sny;
  logic signed [31:0] ax, ay;
  logic signed [31:0] hx, hy, hz;
  logic signed [31:0] y1, z1;
  logic signed [47:0] p0, p1, p2, p3;
  logic [1:0] lane;
  logic       scan_vld;
  logic       div_start, div_done;
  logic signed [63:0] div_num, div_quo;
  logic [63:0] div_den;
  logic signed [32:0] ex, ey, ez, dmax;

  pcnt_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  always_ff @(posedge clk) begin
    rx <= mem_x[raddr];
    ry <= mem_y[raddr];
    rz <= mem_z[raddr];
    if (we) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
      mem_z[waddr] <= wz;
    end
  end

  assign req_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_OUT);
  assign raddr = (state == ST_IDLE) ? AW'(index) : ptr[AW-1:0];

  assign ex = ($signed({mxx[31], mxx}) - $signed({mnx[31], mnx})) >>> 1;
  assign ey = ($signed({mxy[31], mxy}) - $signed({mny[31], mny})) >>> 1;
  assign ez = ($signed({mxz[31], mxz}) - $signed({mnz[31], mnz})) >>> 1;
  always_comb begin
    dmax = (ex > ey) ? ex : ey;
    if (ez > dmax) begin
      dmax = ez;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req_type == REQ_READ) begin
            state_next = ST_READ;
          end else if (req_type == REQ_APPEND || req_type > REQ_READ) begin
            state_next = ST_IDLE;
          end else if (point_count != '0) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_READ:  state_next = ST_OUT;
      ST_OUT:   if (res_ready) state_next = ST_IDLE;
      ST_SCAN:  if (ptr == point_count && !scan_vld) state_next = ST_SETUP;
      ST_SETUP: begin
        if (op == OP_NORM && dmax == '0) begin
          state_next = ST_IDLE;
        end else if (op == OP_CENTER) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_APPLY;
        end
      end
      ST_DIV:   if (div_done && lane == 2'd2) state_next = ST_APPLY;
      ST_APPLY: begin
        if (ptr == point_count) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        if (op == OP_ROTATE) begin
          state_next = ST_MUL2;
        end else if (op == OP_NORM) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_MUL2:  state_next = ST_WRITE;
      ST_WRITE: state_next = ST_APPLY;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = {31'd0, dval};
    if (state == ST_SETUP && op == OP_CENTER) begin
      div_start = 1'b1;
      div_num   = sx;
      div_den   = 64'(point_count);
    end else if (state == ST_DIV && op == OP_CENTER && div_done && lane != 2'd2) begin
      div_start = 1'b1;
      div_num   = (lane == 2'd0) ? sy : sz;
      div_den   = 64'(point_count);
    end else if (state == ST_MUL1 && op == OP_NORM) begin
      div_start = 1'b1;
      div_num   = 64'(rx) <<< 16;
    end else if (state == ST_DIV && op == OP_NORM && div_done && lane != 2'd2) begin
      div_start = 1'b1;
      div_num   = 64'((lane == 2'd0) ? hy : hz) <<< 16;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= '0;
      we          <= 1'b0;
      scan_vld    <= 1'b0;
    end else begin
      state <= state_next;
      we    <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          ptr <= '0;
          scan_vld <= 1'b0;
          mnx <= '0; mny <= '0; mnz <= '0; mxx <= '0; mxy <= '0; mxz <= '0;
          sx <= '0; sy <= '0; sz <= '0;
          cx <= cos_x; snx <= sin_x; cy <= cos_y; sny <= sin_y;
          ax <= shift_x; ay <= shift_y;
          status <= (IW'(index) >= IW'(point_count));
          fwd <= we && (waddr == raddr);
          if (req_valid) begin
            if (req_type == REQ_APPEND && point_count != CW'(CAPACITY)) begin
              we <= 1'b1;
              waddr <= point_count[AW-1:0];
              wx <= px; wy <= py; wz <= pz;
              point_count <= point_count + 1'b1;
            end
            unique case (req_type)
              REQ_NORM:   op <= OP_NORM;
              REQ_CENTER: op <= OP_CENTER;
              REQ_ROTATE: op <= OP_ROTATE;
              default:    op <= OP_SHIFT;
            endcase
          end
        end
        ST_READ: begin
          out_x <= status ? 32'sd0 : (fwd ? wx : rx);
          out_y <= status ? 32'sd0 : (fwd ? wy : ry);
          out_z <= status ? 32'sd0 : (fwd ? wz : rz);
        end
        ST_SCAN: begin
          if (ptr != point_count) begin
            ptr <= ptr + 1'b1;
          end
          scan_vld <= (ptr != point_count);
          if (scan_vld) begin
            if (rx < mnx) mnx <= rx;
            if (ry < mny) mny <= ry;
            if (rz < mnz) mnz <= rz;
            if (rx > mxx) mxx <= rx;
            if (ry > mxy) mxy <= ry;
            if (rz > mxz) mxz <= rz;
            sx <= sx + 64'(rx);
            sy <= sy + 64'(ry);
            sz <= sz + 64'(rz);
          end
        end
        ST_SETUP: begin
          ptr  <= '0;
          lane <= 2'd0;
          dval <= dmax[32:0];
        end
        ST_DIV: begin
          if (div_done) begin
            lane <= lane + 2'd1;
            if (op == OP_CENTER) begin
              unique case (lane)
                2'd0: mx <= div_quo;
                2'd1: my <= div_quo;
                default: mz <= div_quo;
              endcase
              if (lane == 2'd2) begin
                ptr <= '0;
              end
            end else begin
              unique case (lane)
                2'd0: wx <= sat32(66'(div_quo));
                2'd1: wy <= sat32(66'(div_quo));
                default: wz <= sat32(66'(div_quo));
              endcase
              if (lane == 2'd2) begin
                we    <= 1'b1;
                waddr <= ptr[AW-1:0];
                ptr   <= ptr + 1'b1;
              end
            end
          end
        end
        ST_APPLY: begin
          lane <= 2'd0;
        end
        ST_MUL1: begin
          hx <= rx; hy <= ry; hz <= rz;
          p0 <= ry * cx;
          p1 <= rz * snx;
          p2 <= ry * snx;
          p3 <= rz * cx;
          if (op == OP_CENTER) begin
            wx <= sat32(66'(rx) - 66'(mx));
            wy <= sat32(66'(ry) - 66'(my));
            wz <= sat32(66'(rz) - 66'(mz));
          end else begin
            wx <= sat32(66'(rx) + 66'(ax));
            wy <= sat32(66'(ry) - 66'(ay));
            wz <= rz;
          end
        end
        ST_MUL2: begin
          y1 <= rnd14(66'(p0) - 66'(p1));
          z1 <= rnd14(66'(p2) + 66'(p3));
        end
        ST_WRITE: begin
          we    <= 1'b1;
          waddr <= ptr[AW-1:0];
          ptr   <= ptr + 1'b1;
          if (op == OP_ROTATE) begin
            wx <= rnd14(66'(48'(hx) * 48'(cy)) + 66'(48'(z1) * 48'(sny)));
            wy <= y1;
            wz <= rnd14(66'(48'(z1) * 48'(cy)) - 66'(48'(hx) * 48'(sny)));
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[test/point_cloud_normalize_transform_test.sv]
// Self-checking testbench for the point cloud normalize and transform block.
`timescale 1ns / 1ps

module point_cloud_normalize_transform_test;
  import pcnt_pkg::*;

  localparam int DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] x, y, z;
    logic [9:0]         idx;
    logic signed [15:0] cx, sx, cy, sy;
    logic signed [31:0] dx, dy;
  } request_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               flag;
  } point_read_t;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  logic [2:0] req_type = '0;
  logic signed [31:0] px = '0, py = '0, pz = '0;
  logic [9:0] index = '0;
  logic signed [15:0] cos_x = '0, sin_x = '0, cos_y = '0, sin_y = '0;
  logic signed [31:0] shift_x = '0, shift_y = '0;
  logic res_valid;
  logic res_ready = 0;
  logic signed [31:0] out_x, out_y, out_z;
  logic status;

  request_t pending[$];
  point_read_t expected_reads[$];
  int signed cloud_x[DEPTH], cloud_y[DEPTH], cloud_z[DEPTH];
  int cloud_size = 0;
  int errors = 0;
  int idle_cycles = 0;
  int beats_read = 0;
  bit held_off = 0;

  point_cloud_normalize_transform uut (
    .clk, .rst, .req_valid, .req_ready, .req_type, .px, .py, .pz, .index,
    .cos_x, .sin_x, .cos_y, .sin_y, .shift_x, .shift_y,
    .res_valid, .res_ready, .out_x, .out_y, .out_z, .status
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  function automatic int signed clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int signed round_q14(longint v);
    return clamp32((v + 8192) >>> 14);
  endfunction

  task automatic update_cloud(request_t r);
    longint lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, span, sum_x, sum_y, sum_z;
    longint mean_x, mean_y, mean_z, vx, vy, vz;
    int signed ny, z1;
    point_read_t p;
    lo_x = 0; lo_y = 0; lo_z = 0; hi_x = 0; hi_y = 0; hi_z = 0;
    sum_x = 0; sum_y = 0; sum_z = 0;
    case (r.kind)
      REQ_APPEND: begin
        if (cloud_size < DEPTH) begin
          cloud_x[cloud_size] = r.x;
          cloud_y[cloud_size] = r.y;
          cloud_z[cloud_size] = r.z;
          cloud_size++;
        end
      end
      REQ_NORM: begin
        for (int i = 0; i < cloud_size; i++) begin
          if (cloud_x[i] < lo_x) lo_x = cloud_x[i];
          if (cloud_y[i] < lo_y) lo_y = cloud_y[i];
          if (cloud_z[i] < lo_z) lo_z = cloud_z[i];
          if (cloud_x[i] > hi_x) hi_x = cloud_x[i];
          if (cloud_y[i] > hi_y) hi_y = cloud_y[i];
          if (cloud_z[i] > hi_z) hi_z = cloud_z[i];
        end
        span = (hi_x - lo_x) / 2;
        if ((hi_y - lo_y) / 2 > span) span = (hi_y - lo_y) / 2;
        if ((hi_z - lo_z) / 2 > span) span = (hi_z - lo_z) / 2;
        if (span != 0) begin
          for (int i = 0; i < cloud_size; i++) begin
            cloud_x[i] = clamp32((longint'(cloud_x[i]) * 65536) / span);
            cloud_y[i] = clamp32((longint'(cloud_y[i]) * 65536) / span);
            cloud_z[i] = clamp32((longint'(cloud_z[i]) * 65536) / span);
          end
        end
      end
      REQ_CENTER: begin
        if (cloud_size != 0) begin
          for (int i = 0; i < cloud_size; i++) begin
            sum_x += cloud_x[i];
            sum_y += cloud_y[i];
            sum_z += cloud_z[i];
          end
          mean_x = sum_x / cloud_size;
          mean_y = sum_y / cloud_size;
          mean_z = sum_z / cloud_size;
          for (int i = 0; i < cloud_size; i++) begin
            cloud_x[i] = clamp32(longint'(cloud_x[i]) - mean_x);
            cloud_y[i] = clamp32(longint'(cloud_y[i]) - mean_y);
            cloud_z[i] = clamp32(longint'(cloud_z[i]) - mean_z);
          end
        end
      end
      REQ_ROTATE: begin
        for (int i = 0; i < cloud_size; i++) begin
          vx = cloud_x[i]; vy = cloud_y[i]; vz = cloud_z[i];
          ny = round_q14(vy * r.cx - vz * r.sx);
          z1 = round_q14(vy * r.sx + vz * r.cx);
          cloud_x[i] = round_q14(vx * r.cy + longint'(z1) * r.sy);
          cloud_z[i] = round_q14(longint'(z1) * r.cy - vx * r.sy);
          cloud_y[i] = ny;
        end
      end
      REQ_SHIFT: begin
        for (int i = 0; i < cloud_size; i++) begin
          cloud_x[i] = clamp32(longint'(cloud_x[i]) + longint'(r.dx));
          cloud_y[i] = clamp32(longint'(cloud_y[i]) - longint'(r.dy));
        end
      end
      REQ_READ: begin
        if (r.idx < cloud_size) begin
          p.x = cloud_x[r.idx]; p.y = cloud_y[r.idx]; p.z = cloud_z[r.idx];
          p.flag = 1'b0;
        end else begin
          p.x = '0; p.y = '0; p.z = '0;
          p.flag = 1'b1;
        end
        expected_reads = {expected_reads, p};
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] coord_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h003fffff)) - 32'sh00200000;
    endcase
  endfunction

  function automatic logic signed [15:0] trig_value();
    case ($urandom_range(0, 9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    endcase
  endfunction

  function automatic request_t random_fields(logic [2:0] kind);
    request_t r;
    r.kind = kind;
    r.x = $urandom; r.y = $urandom; r.z = $urandom;
    r.idx = 10'($urandom);
    r.cx = 16'($urandom); r.sx = 16'($urandom);
    r.cy = 16'($urandom); r.sy = 16'($urandom);
    r.dx = $urandom; r.dy = $urandom;
    return r;
  endfunction

  task automatic enqueue(request_t r);
    pending = {pending, r};
  endtask

  // The append function tracks the count so the stimulus knows the store size.
  int planned = 0;

  task automatic queue_append(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
    request_t r;
    r = random_fields(REQ_APPEND);
    r.x = x; r.y = y; r.z = z;
    enqueue(r);
    if (planned < DEPTH) planned++;
  endtask

  task automatic queue_read(int idx);
    request_t r;
    r = random_fields(REQ_READ);
    r.idx = 10'(idx);
    enqueue(r);
  endtask

  task automatic queue_rotate(logic signed [15:0] cx, logic signed [15:0] sx,
                              logic signed [15:0] cy, logic signed [15:0] sy);
    request_t r;
    r = random_fields(REQ_ROTATE);
    r.cx = cx; r.sx = sx; r.cy = cy; r.sy = sy;
    enqueue(r);
  endtask

  task automatic queue_shift(logic signed [31:0] dx, logic signed [31:0] dy);
    request_t r;
    r = random_fields(REQ_SHIFT);
    r.dx = dx; r.dy = dy;
    enqueue(r);
  endtask

  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  request_t on_bus;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_valid && req_ready) begin
        update_cloud(on_bus);
      end
      if (!req_valid || req_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          on_bus = pending.pop_front();
          req_type <= on_bus.kind;
          px <= on_bus.x; py <= on_bus.y; pz <= on_bus.z;
          index <= on_bus.idx;
          cos_x <= on_bus.cx; sin_x <= on_bus.sx;
          cos_y <= on_bus.cy; sin_y <= on_bus.sy;
          shift_x <= on_bus.dx; shift_y <= on_bus.dy;
          req_valid <= 1'b1;
          send_gap <= ($urandom_range(0, 99) < 65) ? 0 :
                      ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3) :
                      $urandom_range(10, 40);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (res_valid && res_ready) begin
        beats_read++;
        if (expected_reads.size() == 0) begin
          $error("unexpected read beat: x=%0d y=%0d z=%0d status=%0d",
                 out_x, out_y, out_z, status);
          errors++;
        end else begin
          point_read_t p;
          p = expected_reads.pop_front();
          if (out_x !== p.x) begin
            $error("out_x expected %0d actual %0d", p.x, out_x);
            errors++;
          end
          if (out_y !== p.y) begin
            $error("out_y expected %0d actual %0d", p.y, out_y);
            errors++;
          end
          if (out_z !== p.z) begin
            $error("out_z expected %0d actual %0d", p.z, out_z);
            errors++;
          end
          if (status !== p.flag) begin
            $error("status expected %0d actual %0d", p.flag, status);
            errors++;
          end
        end
      end
      if (!held_off && beats_read >= 100) begin
        held_off <= 1'b1;
        recv_gap <= 600;
        res_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        res_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 70) begin
        res_ready <= 1'b1;
      end else begin
        res_ready <= 1'b0;
        recv_gap <= ($urandom_range(0, 9) != 0) ? $urandom_range(0, 3) :
                    $urandom_range(10, 50);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (res_valid && res_ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("point_cloud_normalize_transform_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    enqueue(random_fields(REQ_NORM));
    enqueue(random_fields(REQ_CENTER));
    queue_read(0);
    queue_read(1023);
    queue_append(32'sh7fffffff, 32'sh80000000, 32'sh00000000);
    queue_append(32'sh80000000, 32'sh7fffffff, 32'shffffffff);
    queue_append(32'sh00010000, -32'sh00030000, 32'sh00008000);
    queue_read(0);
    queue_read(2);
    queue_read(3);
    queue_shift(32'sh7fffffff, 32'sh80000000);
    queue_read(0);
    queue_rotate(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    queue_read(1);
    enqueue(random_fields(REQ_NORM));
    queue_read(2);
    enqueue(random_fields(REQ_CENTER));
    queue_read(0);
    queue_rotate(16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384);
    queue_read(1);
    enqueue(random_fields(3'd6));
    enqueue(random_fields(3'd7));
    queue_read(2);

    for (int n = 0; n < 900; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35 && planned < 48) begin
        queue_append(coord_value(), coord_value(), coord_value());
      end else if (pick < 80) begin
        queue_read(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, planned + 1));
      end else if (pick < 87) begin
        queue_rotate(trig_value(), trig_value(), trig_value(), trig_value());
      end else if (pick < 93) begin
        queue_shift(($urandom_range(0, 3) == 0) ? $urandom : coord_value(),
                    ($urandom_range(0, 3) == 0) ? $urandom : coord_value());
      end else if (pick < 97) begin
        enqueue(random_fields(REQ_CENTER));
      end else if (pick < 99) begin
        enqueue(random_fields(REQ_NORM));
      end else begin
        enqueue(random_fields(3'($urandom_range(6, 7))));
      end
    end

    while (planned < DEPTH) begin
      queue_append(coord_value(), coord_value(), coord_value());
    end
    queue_append(32'sh11111111, 32'sh22222222, 32'sh33333333);
    queue_append(32'sh44444444, 32'sh55555555, 32'sh66666666);
    queue_read(1023);
    queue_read(0);
    queue_shift($urandom, $urandom);
    queue_read(1023);
    queue_rotate(trig_value(), trig_value(), trig_value(), trig_value());
    queue_read(512);
    enqueue(random_fields(REQ_CENTER));
    for (int n = 0; n < 40; n++) queue_read($urandom_range(0, 1023));

    wait (pending.size() == 0 && !req_valid && expected_reads.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_reads.size() == 0) begin
      $display("point_cloud_normalize_transform_test: PASS");
    end else begin
      $display("point_cloud_normalize_transform_test: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/pcnt_pkg.sv
rtl/pcnt_div.sv
rtl/point_cloud_normalize_transform.sv
test/point_cloud_normalize_transform_test.sv
